// ----- design/afsm_pkg.sv -----
// shared types and constants for the audio frame sequencer and mixer
// no dependencies; imported by every module of the block

package afsm_pkg;

    // bus item kinds
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_STEP_ONE   = 3'd0,
        CFG_STEP_TWO   = 3'd1,
        CFG_STEP_THREE = 3'd2,
        CFG_STEP_FOUR  = 3'd3,
        CFG_STEP_FIVE  = 3'd4,
        CFG_FOUR_TOTAL = 3'd5,
        CFG_FIVE_TOTAL = 3'd6
    } t_cfg_reg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] STEP_ONE_RST   = 16'd7457;
    localparam logic [15:0] STEP_TWO_RST   = 16'd14913;
    localparam logic [15:0] STEP_THREE_RST = 16'd22371;
    localparam logic [15:0] STEP_FOUR_RST  = 16'd29829;
    localparam logic [15:0] STEP_FIVE_RST  = 16'd37281;
    localparam logic [15:0] FOUR_TOTAL_RST = 16'd29830;
    localparam logic [15:0] FIVE_TOTAL_RST = 16'd37282;

    localparam logic [15:0] ADDR_STATUS    = 16'h4015;
    localparam logic [15:0] ADDR_FRAME_CTR = 16'h4017;
    localparam logic [7:0]  MODE_BIT_MASK  = 8'h80;
    localparam logic [7:0]  INHIBIT_MASK   = 8'h40;
    localparam logic [2:0]  RESTART_DELAY  = 3'd4;

    // mixer lookup tables
    localparam int PULSE_TABLE_SIZE = 31;
    localparam int TND_TABLE_SIZE   = 203;
    localparam int PULSE_IDX_W      = $clog2(PULSE_TABLE_SIZE);
    localparam int TND_IDX_W        = $clog2(TND_TABLE_SIZE);
    localparam int PULSE_W          = 14;
    localparam int TND_W            = 15;
    localparam int SAMPLE_W         = 15;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    // entry(n) = floor(gain*n*FULL_SCALE / (SCALE_DEN*(bias + LEVEL_STEP*n)))
    localparam longint unsigned PULSE_GAIN = 64'd9552;
    localparam longint unsigned PULSE_BIAS = 64'd8128;
    localparam longint unsigned TND_GAIN   = 64'd16367;
    localparam longint unsigned TND_BIAS   = 64'd24329;
    localparam longint unsigned FULL_SCALE = 64'd65535;
    localparam longint unsigned SCALE_DEN  = 64'd200;
    localparam longint unsigned LEVEL_STEP = 64'd100;

    // one result transaction
    typedef struct packed {
        logic                quarter_frame;
        logic                half_frame;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] mixed_sample;
        logic [7:0]          read_data;
        logic                frame_irq;
    } t_result;

endpackage

// ----- design/afsm_mixer.sv -----
// nonlinear mixer: pulse and tnd lookup tables plus saturating sum
// depends on afsm_pkg for table sizes, formula constants and widths

module afsm_mixer
    import afsm_pkg::*;
(
    input  logic [3:0]          i_pulse_one_level,
    input  logic [3:0]          i_pulse_two_level,
    input  logic [3:0]          i_triangle_level,
    input  logic [3:0]          i_noise_level,
    input  logic [6:0]          i_delta_level,
    output logic [SAMPLE_W-1:0] o_sample
);

    logic [PULSE_W-1:0] pulse_rom [PULSE_TABLE_SIZE];
    logic [TND_W-1:0]   tnd_rom   [TND_TABLE_SIZE];

    // tables are fixed at elaboration from the exact rational formula, truncated
    for (genvar n = 0; n < PULSE_TABLE_SIZE; n++) begin : g_pulse
        localparam longint unsigned Entry = (PULSE_GAIN * n * FULL_SCALE) /
            (SCALE_DEN * (PULSE_BIAS + LEVEL_STEP * n));
        assign pulse_rom[n] = Entry[PULSE_W-1:0];
    end

    for (genvar n = 0; n < TND_TABLE_SIZE; n++) begin : g_tnd
        localparam longint unsigned Entry = (TND_GAIN * n * FULL_SCALE) /
            (SCALE_DEN * (TND_BIAS + LEVEL_STEP * n));
        assign tnd_rom[n] = Entry[TND_W-1:0];
    end

    logic [PULSE_IDX_W-1:0] pulse_idx;
    logic [PULSE_IDX_W-1:0] pulse_sel;
    logic [TND_IDX_W-1:0]   tnd_idx;
    logic [TND_IDX_W-1:0]   tnd_sel;
    logic [TND_W:0]         sum;

    always_comb begin
        pulse_idx = PULSE_IDX_W'(i_pulse_one_level) + PULSE_IDX_W'(i_pulse_two_level);
        tnd_idx   = TND_IDX_W'({i_triangle_level, 1'b0}) + TND_IDX_W'(i_triangle_level)
                  + TND_IDX_W'({i_noise_level, 1'b0}) + TND_IDX_W'(i_delta_level);

        // clamp to the last entry
        pulse_sel = (pulse_idx > PULSE_IDX_W'(PULSE_TABLE_SIZE - 1))
                  ? PULSE_IDX_W'(PULSE_TABLE_SIZE - 1) : pulse_idx;
        tnd_sel   = (tnd_idx > TND_IDX_W'(TND_TABLE_SIZE - 1))
                  ? TND_IDX_W'(TND_TABLE_SIZE - 1) : tnd_idx;

        sum = (TND_W + 1)'(pulse_rom[pulse_sel]) + (TND_W + 1)'(tnd_rom[tnd_sel]);

        if (sum > (TND_W + 1)'(SAMPLE_MAX)) begin
            o_sample = SAMPLE_MAX;
        end else begin
            o_sample = sum[SAMPLE_W-1:0];
        end
    end

endmodule

// ----- design/afsm_frame_seq.sv -----
// frame sequencer: step registers, position counter, restart countdown,
// status read and frame interrupt flag; depends on afsm_pkg

module afsm_frame_seq
    import afsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_fire,
    input  logic [1:0]             i_opcode,
    input  logic [15:0]            i_bus_address,
    input  logic [7:0]             i_write_data,
    input  logic [4:0]             i_channel_status,
    input  logic                   i_dmc_irq,
    input  logic [SAMPLE_W-1:0]    i_sample,
    output t_result                o_result
);

    logic [15:0] r_step_one, r_step_two, r_step_three, r_step_four, r_step_five;
    logic [15:0] r_four_total, r_five_total;

    logic [15:0] r_tick_count, n_tick_count;
    logic        r_tick_parity, n_tick_parity;
    logic        r_five_step, n_five_step;
    logic        r_irq_inhibit, n_irq_inhibit;
    logic        r_frame_flag, n_frame_flag;
    logic [2:0]  r_countdown, n_countdown;

    logic [15:0] total;
    logic [15:0] base_count;
    logic        base_parity;
    logic [16:0] next_count;
    logic        hit_quarter, hit_half, hit_four;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_one   <= STEP_ONE_RST;
            r_step_two   <= STEP_TWO_RST;
            r_step_three <= STEP_THREE_RST;
            r_step_four  <= STEP_FOUR_RST;
            r_step_five  <= STEP_FIVE_RST;
            r_four_total <= FOUR_TOTAL_RST;
            r_five_total <= FIVE_TOTAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_ONE:   r_step_one   <= i_cfg_data;
                CFG_STEP_TWO:   r_step_two   <= i_cfg_data;
                CFG_STEP_THREE: r_step_three <= i_cfg_data;
                CFG_STEP_FOUR:  r_step_four  <= i_cfg_data;
                CFG_STEP_FIVE:  r_step_five  <= i_cfg_data;
                CFG_FOUR_TOTAL: r_four_total <= i_cfg_data;
                CFG_FIVE_TOTAL: r_five_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tick_count  = r_tick_count;
        n_tick_parity = r_tick_parity;
        n_five_step   = r_five_step;
        n_irq_inhibit = r_irq_inhibit;
        n_frame_flag  = r_frame_flag;
        n_countdown   = r_countdown;

        o_result = '0;

        total       = r_five_step ? r_five_total : r_four_total;
        base_count  = r_tick_count;
        base_parity = r_tick_parity;
        next_count  = '0;

        // step compares always use the position before the countdown rezero
        hit_quarter = (r_tick_count == r_step_one) || (r_tick_count == r_step_three);
        hit_four    = !r_five_step && (r_tick_count == r_step_four);
        hit_half    = (r_tick_count == r_step_two) || hit_four
                    || (r_five_step && (r_tick_count == r_step_five));

        case (t_opcode'(i_opcode))
            OP_TICK: begin
                if (r_countdown != 3'd0) begin
                    n_countdown = r_countdown - 3'd1;
                    if (r_countdown == 3'd1) begin
                        base_count  = '0;
                        base_parity = 1'b0;
                        if (r_five_step) begin
                            o_result.quarter_frame = 1'b1;
                            o_result.half_frame    = 1'b1;
                        end
                    end
                end
                if (hit_quarter || hit_half) begin
                    o_result.quarter_frame = 1'b1;
                end
                if (!hit_quarter && hit_half) begin
                    o_result.half_frame = 1'b1;
                end
                if (hit_four && !r_irq_inhibit) begin
                    n_frame_flag = 1'b1;
                end
                if (!base_parity) begin
                    o_result.sample_valid = 1'b1;
                    o_result.mixed_sample = i_sample;
                end
                // a total of zero or a position left past the total wraps to zero
                next_count = {1'b0, base_count} + 17'd1;
                if (next_count >= {1'b0, total}) begin
                    next_count = '0;
                end
                n_tick_count  = next_count[15:0];
                n_tick_parity = ~base_parity;
            end
            OP_WRITE: begin
                if (i_bus_address == ADDR_FRAME_CTR) begin
                    n_five_step   = |(i_write_data & MODE_BIT_MASK);
                    n_irq_inhibit = |(i_write_data & INHIBIT_MASK);
                    n_countdown   = RESTART_DELAY;
                    n_tick_count  = '0;
                    n_tick_parity = 1'b0;
                    o_result.half_frame = n_five_step;
                end
            end
            OP_READ: begin
                if (i_bus_address == ADDR_STATUS) begin
                    o_result.read_data = {i_dmc_irq, r_frame_flag, 1'b0, i_channel_status};
                    n_frame_flag = 1'b0;
                end
            end
            default: ;
        endcase

        o_result.frame_irq = n_frame_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_tick_parity <= 1'b0;
            r_five_step   <= 1'b0;
            r_irq_inhibit <= 1'b0;
            r_frame_flag  <= 1'b0;
            r_countdown   <= '0;
        end else if (i_fire) begin
            r_tick_count  <= n_tick_count;
            r_tick_parity <= n_tick_parity;
            r_five_step   <= n_five_step;
            r_irq_inhibit <= n_irq_inhibit;
            r_frame_flag  <= n_frame_flag;
            r_countdown   <= n_countdown;
        end
    end

endmodule

// ----- design/apu_frame_sequencer_mixer.sv -----
// top level of the audio frame sequencer with nonlinear mixer
// depends on afsm_pkg, afsm_mixer and afsm_frame_seq

// Every transaction (tick, bus write or bus read) produces exactly one result
// transaction, and a new transaction can be accepted in every cycle while
// o_in_stall is low: the sequencer compares, the table lookups and the
// saturating add all sit between the input ports and the output register.
// A two-entry output buffer keeps taking one more transaction while the
// output is stalled; o_in_stall rises only when both entries are full.
// Configuration writes are always ready and take effect on the next cycle;
// they are meant to be written while no transaction is in flight.

module apu_frame_sequencer_mixer
    import afsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_opcode,
    input  logic [15:0]            i_bus_address,
    input  logic [7:0]             i_write_data,
    input  logic [4:0]             i_channel_status,
    input  logic                   i_dmc_irq,
    input  logic [3:0]             i_pulse_one_level,
    input  logic [3:0]             i_pulse_two_level,
    input  logic [3:0]             i_triangle_level,
    input  logic [3:0]             i_noise_level,
    input  logic [6:0]             i_delta_level,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_quarter_frame,
    output logic                   o_half_frame,
    output logic                   o_sample_valid,
    output logic [SAMPLE_W-1:0]    o_mixed_sample,
    output logic [7:0]             o_read_data,
    output logic                   o_frame_irq
);

    logic [SAMPLE_W-1:0] sample;
    t_result             result;
    logic                in_fire, out_fire;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;

    afsm_mixer u_mixer (
        .i_pulse_one_level (i_pulse_one_level),
        .i_pulse_two_level (i_pulse_two_level),
        .i_triangle_level  (i_triangle_level),
        .i_noise_level     (i_noise_level),
        .i_delta_level     (i_delta_level),
        .o_sample          (sample)
    );

    afsm_frame_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_fire           (in_fire),
        .i_opcode         (i_opcode),
        .i_bus_address    (i_bus_address),
        .i_write_data     (i_write_data),
        .i_channel_status (i_channel_status),
        .i_dmc_irq        (i_dmc_irq),
        .i_sample         (sample),
        .o_result         (result)
    );

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_quarter_frame = r_out.quarter_frame;
    assign o_half_frame    = r_out.half_frame;
    assign o_sample_valid  = r_out.sample_valid;
    assign o_mixed_sample  = r_out.mixed_sample;
    assign o_read_data     = r_out.read_data;
    assign o_frame_irq     = r_out.frame_irq;

endmodule

// ----- dv/apu_frame_sequencer_mixer_tb.sv -----
// self-checking testbench for the audio frame sequencer and nonlinear mixer
// depends on afsm_pkg and apu_frame_sequencer_mixer; the scoreboard class predicts every result
// transaction from its own copy of the sequencer state, table formula and step registers

module apu_frame_sequencer_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afsm_pkg::*;

    // opcode 3 is not in the package enum but is a legal no-op on the port
    localparam logic [1:0] OP_IDLE = 2'd3;

    localparam int PHASES        = 14;
    localparam int ITEMS_PER_SET = 105;
    localparam int HOLD_CYCLES   = 40;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [4:0]  channel_status;
        logic        dmc_irq;
        logic [3:0]  pulse_one_level;
        logic [3:0]  pulse_two_level;
        logic [3:0]  triangle_level;
        logic [3:0]  noise_level;
        logic [6:0]  delta_level;
    } t_bus_item;

    // truncated value of gain*n*65535 / (200*(bias + 100*n)), index clamped to the last entry
    function automatic int unsigned dac_level(longint unsigned gain, longint unsigned bias,
                                              int unsigned n, int unsigned last);
        longint unsigned k;
        k = (n > last) ? last : n;
        if (k == 0)
            return 0;
        return 32'((gain * k * 64'd65535) / (64'd200 * (bias + 64'd100 * k)));
    endfunction

    class frame_mix_scoreboard;
        logic [15:0] step_reg [7];
        logic [15:0] position;
        logic        parity;
        logic        five_step;
        logic        inhibit;
        logic        frame_flag;
        logic [2:0]  restart_left;
        t_result     due_results [$];
        int          mismatches;
        int          checked;
        int          samples;
        int          quarters;
        int          halves;
        int          irq_reads;

        function new();
            step_reg[CFG_STEP_ONE]   = STEP_ONE_RST;
            step_reg[CFG_STEP_TWO]   = STEP_TWO_RST;
            step_reg[CFG_STEP_THREE] = STEP_THREE_RST;
            step_reg[CFG_STEP_FOUR]  = STEP_FOUR_RST;
            step_reg[CFG_STEP_FIVE]  = STEP_FIVE_RST;
            step_reg[CFG_FOUR_TOTAL] = FOUR_TOTAL_RST;
            step_reg[CFG_FIVE_TOTAL] = FIVE_TOTAL_RST;
            position     = '0;
            parity       = 1'b0;
            five_step    = 1'b0;
            inhibit      = 1'b0;
            frame_flag   = 1'b0;
            restart_left = '0;
        endfunction

        function void apply_config(t_cfg_reg idx, logic [15:0] val);
            step_reg[idx] = val;
        endfunction

        function void note_bus_item(t_bus_item it);
            t_result     want;
            logic [15:0] cur;
            logic [15:0] total;
            int unsigned nxt;
            int unsigned level;
            int unsigned pulse_idx;
            int unsigned tnd_idx;
            want = '0;
            case (it.opcode)
                OP_TICK: begin
                    cur   = position;
                    total = five_step ? step_reg[CFG_FIVE_TOTAL] : step_reg[CFG_FOUR_TOTAL];
                    if (restart_left != 0) begin
                        restart_left = restart_left - 3'd1;
                        if (restart_left == 0) begin
                            position = '0;
                            parity   = 1'b0;
                            if (five_step) begin
                                want.quarter_frame = 1'b1;
                                want.half_frame    = 1'b1;
                            end
                        end
                    end
                    // step compares use the position from before the countdown
                    if (cur == step_reg[CFG_STEP_ONE] || cur == step_reg[CFG_STEP_THREE]) begin
                        want.quarter_frame = 1'b1;
                    end else if (cur == step_reg[CFG_STEP_TWO] ||
                                 (!five_step && cur == step_reg[CFG_STEP_FOUR]) ||
                                 (five_step && cur == step_reg[CFG_STEP_FIVE])) begin
                        want.quarter_frame = 1'b1;
                        want.half_frame    = 1'b1;
                    end
                    if (!five_step && cur == step_reg[CFG_STEP_FOUR] && !inhibit)
                        frame_flag = 1'b1;
                    if (!parity) begin
                        pulse_idx = it.pulse_one_level + it.pulse_two_level;
                        tnd_idx   = 3 * it.triangle_level + 2 * it.noise_level + it.delta_level;
                        level = dac_level(9552, 8128, pulse_idx, 30) +
                                dac_level(16367, 24329, tnd_idx, 202);
                        if (level > 32767)
                            level = 32767;
                        want.sample_valid = 1'b1;
                        want.mixed_sample = level[SAMPLE_W-1:0];
                    end
                    nxt = position + 1;
                    if (nxt >= total)
                        nxt = 0;
                    position = nxt[15:0];
                    parity   = ~parity;
                end
                OP_WRITE: begin
                    if (it.bus_address == ADDR_FRAME_CTR) begin
                        five_step    = (it.write_data & MODE_BIT_MASK) != 0;
                        inhibit      = (it.write_data & INHIBIT_MASK) != 0;
                        restart_left = RESTART_DELAY;
                        position     = '0;
                        parity       = 1'b0;
                        if (five_step)
                            want.half_frame = 1'b1;
                    end
                end
                OP_READ: begin
                    if (it.bus_address == ADDR_STATUS) begin
                        want.read_data = {it.dmc_irq, frame_flag, 1'b0, it.channel_status};
                        frame_flag     = 1'b0;
                    end
                end
                default: ;
            endcase
            want.frame_irq = frame_flag;
            due_results = {due_results, want};
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("mismatch at %0t ns, result %0d: %s got %0h expected %0h",
                         $time, checked, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", got, '0);
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (got.quarter_frame !== want.quarter_frame)
                report_mismatch("quarter_frame", got.quarter_frame, want.quarter_frame);
            if (got.half_frame !== want.half_frame)
                report_mismatch("half_frame", got.half_frame, want.half_frame);
            if (got.sample_valid !== want.sample_valid)
                report_mismatch("sample_valid", got.sample_valid, want.sample_valid);
            if (got.mixed_sample !== want.mixed_sample)
                report_mismatch("mixed_sample", got.mixed_sample, want.mixed_sample);
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.frame_irq !== want.frame_irq)
                report_mismatch("frame_irq", got.frame_irq, want.frame_irq);
            samples  += want.sample_valid;
            quarters += want.quarter_frame;
            halves   += want.half_frame;
            if (want.read_data[6])
                irq_reads++;
        endtask
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   i_out_stall  = 1'b0;
    t_bus_item              cur_item     = '{default: '0};
    logic                   o_cfg_ready;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_quarter_frame;
    logic                   o_half_frame;
    logic                   o_sample_valid;
    logic [SAMPLE_W-1:0]    o_mixed_sample;
    logic [7:0]             o_read_data;
    logic                   o_frame_irq;

    bit                     idle_on      = 1'b1;
    bit                     hold_request = 1'b0;
    frame_mix_scoreboard    board        = new();

    always #5 i_clk = ~i_clk;

    apu_frame_sequencer_mixer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (cur_item.opcode),
        .i_bus_address     (cur_item.bus_address),
        .i_write_data      (cur_item.write_data),
        .i_channel_status  (cur_item.channel_status),
        .i_dmc_irq         (cur_item.dmc_irq),
        .i_pulse_one_level (cur_item.pulse_one_level),
        .i_pulse_two_level (cur_item.pulse_two_level),
        .i_triangle_level  (cur_item.triangle_level),
        .i_noise_level     (cur_item.noise_level),
        .i_delta_level     (cur_item.delta_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_quarter_frame   (o_quarter_frame),
        .o_half_frame      (o_half_frame),
        .o_sample_valid    (o_sample_valid),
        .o_mixed_sample    (o_mixed_sample),
        .o_read_data       (o_read_data),
        .o_frame_irq       (o_frame_irq)
    );

    // output side first: a result never belongs to the transaction taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_result({o_quarter_frame, o_half_frame, o_sample_valid,
                                    o_mixed_sample, o_read_data, o_frame_irq});
            if (i_in_valid && !o_in_stall)
                board.note_bus_item(cur_item);
        end
    end

    function automatic t_bus_item make_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        t_bus_item it;
        it.opcode          = op;
        it.bus_address     = addr;
        it.write_data      = data;
        it.channel_status  = 5'($urandom_range(0, 31));
        it.dmc_irq         = 1'($urandom_range(0, 1));
        it.pulse_one_level = 4'($urandom_range(0, 15));
        it.pulse_two_level = 4'($urandom_range(0, 15));
        it.triangle_level  = 4'($urandom_range(0, 15));
        it.noise_level     = 4'($urandom_range(0, 15));
        it.delta_level     = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // mostly ticks, with frame counter writes and status reads mixed in, plus some noise
    function automatic t_bus_item random_item();
        t_bus_item   it;
        int unsigned pick;
        it   = make_item(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.opcode = OP_TICK;
        end else if (pick < 78) begin
            it.opcode      = OP_WRITE;
            it.bus_address = ADDR_FRAME_CTR;
        end else if (pick < 81) begin
            it.opcode = OP_WRITE;
        end else if (pick < 90) begin
            it.opcode      = OP_READ;
            it.bus_address = ADDR_STATUS;
        end else if (pick < 95) begin
            it.opcode = OP_READ;
        end else begin
            it.opcode = OP_IDLE;
        end
        return it;
    endfunction

    function automatic int pick_gap();
        if (idle_on && $urandom_range(0, 4) == 0)
            return $urandom_range(1, 8);
        return 0;
    endfunction

    task automatic send_item(input t_bus_item it, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cur_item   <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_cfg(input t_cfg_reg idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.apply_config(idx, val);
    endtask

    // stop offering and wait until every outstanding result has been checked
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin : receiver
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold         = HOLD_CYCLES;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 8);
            end else begin
                hold = 0;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    initial begin : stimulus
        t_bus_item   it;
        logic [15:0] val;
        int          set;
        int          idx;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // mixer extremes: silent, odd tick with full levels, then a sample at full levels
        it = make_item(OP_TICK, 16'h0000, 8'h00);
        it.pulse_one_level = 4'd0;
        it.pulse_two_level = 4'd0;
        it.triangle_level  = 4'd0;
        it.noise_level     = 4'd0;
        it.delta_level     = 7'd0;
        send_item(it, 0);
        it.pulse_one_level = 4'hf;
        it.pulse_two_level = 4'hf;
        it.triangle_level  = 4'hf;
        it.noise_level     = 4'hf;
        it.delta_level     = 7'h7f;
        send_item(it, 0);
        send_item(it, pick_gap());
        // status read with all channel status and dmc irq bits set, then off-address accesses
        it = make_item(OP_READ, ADDR_STATUS, 8'h00);
        it.channel_status = 5'h1f;
        it.dmc_irq        = 1'b1;
        send_item(it, 0);
        send_item(make_item(OP_READ, 16'hffff, 8'h00), 0);
        send_item(make_item(OP_WRITE, 16'h0000, 8'hff), 0);
        it = make_item(OP_IDLE, 16'hffff, 8'hff);
        it.channel_status = 5'h1f;
        it.dmc_irq        = 1'b1;
        send_item(it, 0);
        // frame counter writes in both modes, countdown running out and restarted
        send_item(make_item(OP_WRITE, ADDR_FRAME_CTR, 8'hc0), 0);
        repeat (5) send_item(make_item(OP_TICK, 16'h0000, 8'h00), pick_gap());
        send_item(make_item(OP_WRITE, ADDR_FRAME_CTR, 8'h00), 0);
        repeat (4) send_item(make_item(OP_TICK, 16'h0000, 8'h00), pick_gap());
        send_item(make_item(OP_WRITE, ADDR_FRAME_CTR, MODE_BIT_MASK), 0);
        repeat (2) send_item(make_item(OP_TICK, 16'h0000, 8'h00), 0);
        send_item(make_item(OP_WRITE, ADDR_FRAME_CTR, INHIBIT_MASK), 0);
        repeat (4) send_item(make_item(OP_TICK, 16'h0000, 8'h00), pick_gap());
        settle();

        for (set = 0; set < PHASES; set++) begin
            // settings of all 16'hffff, then all 16'h0001, then short sequences so steps get hit
            for (idx = 0; idx < 7; idx++) begin
                if (set == 0)
                    val = 16'hffff;
                else if (set == 1)
                    val = 16'h0001;
                else if (idx >= CFG_FOUR_TOTAL)
                    val = 16'($urandom_range(2, 30));
                else
                    val = 16'($urandom_range(1, 32));
                write_cfg(t_cfg_reg'(idx), val);
            end
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            idle_on = (set % 4 != 2) && (set != PHASES - 1);
            if (set == 3)
                hold_request = 1'b1;
            repeat (ITEMS_PER_SET) send_item(random_item(), pick_gap());
            settle();
        end

        $display("covered %0d transactions over %0d register settings plus the reset one",
                 board.checked, PHASES);
        $display("saw %0d mixed samples, %0d quarter-frame and %0d half-frame events, %0d irq reads",
                 board.samples, board.quarters, board.halves, board.irq_reads);
        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", board.due_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
